// ----- rtl/core/mwg_pkg.sv -----
// Shared types, register codes and sine table builder for the waveform generator.
package mwg_pkg;

	localparam int CFG_DATA_BITS  = 32;
	localparam int CFG_INDEX_BITS = 2;
	localparam int STEP_BITS      = 32;
	localparam int AMP_BITS       = 15;
	localparam int OFFSET_BITS    = 16;
	localparam int ROM_BITS       = 15;
	localparam int WAVE_BITS      = 17;

	localparam int DEF_PHASE_BITS     = 32;
	localparam int DEF_SINE_ADDR_BITS = 10;
	localparam int DEF_SAMPLE_BITS    = 16;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [1:0] {
		SHAPE_SQUARE   = 2'd0,
		SHAPE_SINE     = 2'd1,
		SHAPE_TRIANGLE = 2'd2,
		SHAPE_SAWTOOTH = 2'd3
	} shape_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_WAVE_SHAPE   = 2'd0,
		REG_PHASE_STEP   = 2'd1,
		REG_AMPLITUDE    = 2'd2,
		REG_LEVEL_OFFSET = 2'd3
	} reg_index_t;

	// Quarter-wave sine entry at the midpoint of slot idx, Taylor series in Q2.30.
	function automatic logic [ROM_BITS-1:0] sine_entry(input int idx, input int addr_bits);
		longint unsigned a;
		longint unsigned a2;
		longint unsigned t;
		longint          sum;
		longint unsigned v;
		a   = (HALF_PI_Q30 * longint'(2 * idx + 1)) >> (addr_bits + 1);
		a2  = (a * a) >> 30;
		t   = a;
		sum = longint'(a);
		for (int n = 1; n <= 5; n++) begin
			t = (t * a2) >> 30;
			case (n)
				1:       t = t / 6;
				2:       t = t / 20;
				3:       t = t / 42;
				4:       t = t / 72;
				default: t = t / 110;
			endcase
			if ((n % 2) == 1)
				sum = sum - longint'(t);
			else
				sum = sum + longint'(t);
		end
		if (sum < 0)
			sum = 0;
		v = (longint'(sum) * 32767 + (64'd1 << 29)) >> 30;
		if (v > 32767)
			v = 32767;
		return ROM_BITS'(v);
	endfunction

endpackage

// ----- rtl/core/multi_waveform_generator.sv -----
// Top level of the multi-shape direct digital synthesis generator.
// Each accepted item optionally advances the phase accumulator by phase_step and
// yields one sample: square, sine (quarter-wave table), triangle or sawtooth, scaled
// by amplitude with rounding, plus level_offset, saturated to SAMPLE_BITS signed.
// An item is accepted every cycle while the output side takes results; each result
// moves through the registered stages (phase register, table read, multiply, round
// and saturate), and the sine table read is the registered port of a constant ROM.
// The whole pipeline stalls together while a result waits at the output.
module multi_waveform_generator
	import mwg_pkg::*;
#(
	parameter int PHASE_BITS     = DEF_PHASE_BITS,
	parameter int SINE_ADDR_BITS = DEF_SINE_ADDR_BITS,
	parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [CFG_DATA_BITS-1:0]      cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          advance,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] sample
);

	localparam int ROM_DEPTH = 1 << SINE_ADDR_BITS;
	localparam int SUM_W     = (SAMPLE_BITS > 17) ? SAMPLE_BITS + 2 : 20;
	localparam int PROD_W    = AMP_BITS + 1 + WAVE_BITS;
	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);
	localparam logic [PHASE_BITS-1:0] QUARTER = PHASE_BITS'(1) << (PHASE_BITS - 2);

	// configuration registers
	shape_t                        shape_q;
	logic [STEP_BITS-1:0]          phase_step_q;
	logic [AMP_BITS-1:0]           amplitude_q;
	logic signed [OFFSET_BITS-1:0] level_offset_q;

	logic [PHASE_BITS-1:0] phase_acc_q;
	logic [PHASE_BITS-1:0] phase_next;

	logic                  run;
	logic                  accept;
	logic                  valid_s1, valid_s2, valid_s3;
	logic [PHASE_BITS-1:0] phase_s1;

	logic [ROM_BITS-1:0]          sine_rom [ROM_DEPTH];
	logic [ROM_BITS-1:0]          rom_s2;
	logic                         neg_s2;
	logic signed [WAVE_BITS-1:0]  other_s2;
	logic signed [PROD_W-1:0]     prod_s3;

	logic [1:0]                   quad;
	logic [SINE_ADDR_BITS-1:0]    rom_addr;
	logic [PHASE_BITS-1:0]        tri_y, tri_ny, tri_d;
	logic [PHASE_BITS+16:0]       tri_wide;
	logic [17:0]                  tri_drop;
	logic [17:0]                  tri_w;
	logic signed [WAVE_BITS-1:0]  other_w;
	logic signed [WAVE_BITS-1:0]  wave_w;
	logic signed [PROD_W:0]       rounded;
	logic signed [PROD_W-15:0]    scaled;
	logic signed [SUM_W-1:0]      level;
	logic signed [SUM_W-1:0]      level_sat;

	for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
		assign sine_rom[g] = sine_entry(g, SINE_ADDR_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_q        <= SHAPE_SINE;
			phase_step_q   <= '0;
			amplitude_q    <= '0;
			level_offset_q <= '0;
		end else if (cfg_write) begin
			case (reg_index_t'(cfg_index))
				REG_WAVE_SHAPE:   shape_q        <= shape_t'(cfg_data[1:0]);
				REG_PHASE_STEP:   phase_step_q   <= cfg_data[STEP_BITS-1:0];
				REG_AMPLITUDE:    amplitude_q    <= cfg_data[AMP_BITS-1:0];
				REG_LEVEL_OFFSET: level_offset_q <= cfg_data[OFFSET_BITS-1:0];
				default:          ;
			endcase
		end
	end

	// whole pipeline moves when the output register is free or being taken
	assign run      = !out_valid || out_ready;
	assign in_ready = run;
	assign accept   = in_valid && in_ready;

	assign phase_next = advance ? phase_acc_q + PHASE_BITS'(phase_step_q) : phase_acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_acc_q <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid   <= 1'b0;
		end else if (run) begin
			if (accept)
				phase_acc_q <= phase_next;
			valid_s1  <= accept;
			valid_s2  <= valid_s1;
			valid_s3  <= valid_s2;
			out_valid <= valid_s3;
		end
	end

	// stage 1 -> 2: table address and the non-sine shapes
	always_comb begin
		quad     = phase_s1[PHASE_BITS-1 -: 2];
		rom_addr = phase_s1[PHASE_BITS-3 -: SINE_ADDR_BITS];
		if (quad[0])
			rom_addr = ~rom_addr;

		tri_y    = phase_s1 - QUARTER;
		tri_ny   = -tri_y;
		tri_d    = (tri_y > tri_ny) ? tri_ny : tri_y;
		tri_wide = {tri_d, 17'b0} >> PHASE_BITS;
		tri_drop = tri_wide[17:0];
		tri_w    = 18'd32768 - tri_drop;

		case (shape_q)
			SHAPE_SQUARE: begin
				if ((phase_s1 != '0) && !phase_s1[PHASE_BITS-1])
					other_w = WAVE_BITS'(32768);
				else
					other_w = -WAVE_BITS'(32768);
			end
			SHAPE_TRIANGLE: other_w = tri_w[WAVE_BITS-1:0];
			SHAPE_SAWTOOTH: other_w = WAVE_BITS'($signed(phase_s1[PHASE_BITS-1 -: 16]));
			default:        other_w = '0;
		endcase
	end

	// stage 2 -> 3: signed sine value or other shape, then scale
	always_comb begin
		if (shape_q == SHAPE_SINE)
			wave_w = neg_s2 ? -$signed({2'b00, rom_s2}) : $signed({2'b00, rom_s2});
		else
			wave_w = other_s2;
	end

	// stage 3 -> out: round, offset, saturate
	always_comb begin
		rounded = (PROD_W + 1)'(prod_s3) + (PROD_W + 1)'(16384);
		scaled  = rounded[PROD_W:15];
		level   = SUM_W'(scaled) + SUM_W'(level_offset_q);
		if (level > SAT_HI)
			level_sat = SAT_HI;
		else if (level < SAT_LO)
			level_sat = SAT_LO;
		else
			level_sat = level;
	end

	always_ff @(posedge clk) begin
		if (run) begin
			if (accept)
				phase_s1 <= phase_next;
			rom_s2   <= sine_rom[rom_addr];
			neg_s2   <= quad[1];
			other_s2 <= other_w;
			prod_s3  <= PROD_W'($signed({1'b0, amplitude_q})) * PROD_W'(wave_w);
			sample   <= level_sat[SAMPLE_BITS-1:0];
		end
	end

	// phase moves only on an accepted item that asks to advance
	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_valid && in_ready && advance) |=> $stable(phase_acc_q))
		else $error("phase accumulator moved without an advancing item");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> valid_s1)
		else $error("accepted item did not enter the pipeline");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(valid_s3))
		else $error("result appeared without an item behind it");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !run) |=> valid_s3)
		else $error("item lost while the output stalled");

endmodule

// ----- tb/sv/multi_waveform_generator_test.sv -----
// Self-checking testbench for the multi-shape DDS waveform generator.
module multi_waveform_generator_test;
	import mwg_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT    = 400000;
	localparam int RANDOM_PHASES  = 12;
	localparam int PHASE_ITEMS    = 154;
	localparam int DIRECTED_COUNT = 25;

	typedef longint unsigned u64_t;

	typedef struct packed {
		logic [31:0]        shape;
		logic [31:0]        step;
		logic [31:0]        amp;
		logic [31:0]        off;
		logic               adv;
		logic               known;
		logic signed [15:0] want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic advance = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [DEF_SAMPLE_BITS-1:0] sample;

	// tags that travel with the item on the input side
	logic row_known = 1'b0;
	logic signed [15:0] row_want = '0;

	// predictor copy of the registers and the accumulator
	shape_t shape_q = SHAPE_SINE;
	logic [31:0] step_q = '0;
	logic [AMP_BITS-1:0] amp_q = '0;
	logic signed [OFFSET_BITS-1:0] off_q = '0;
	logic [31:0] phase_q = '0;
	logic [ROM_BITS-1:0] quarter_sine [1 << DEF_SINE_ADDR_BITS];

	logic signed [15:0] expected_samples [$];
	int idle_mode = 0;
	int stall_left = 0;
	int cycle_count = 0;
	int mismatch_count = 0;
	int item_count = 0;
	int sample_count = 0;
	int settings_count = 0;

	stim_row_t directed_rows [DIRECTED_COUNT];

	multi_waveform_generator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.advance   (advance),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sample    (sample)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// quarter-wave table: Taylor series at the slot midpoints, Q2.30
	initial begin : build_quarter_sine
		u64_t a;
		u64_t a2;
		u64_t t;
		longint sum;
		u64_t v;
		for (int i = 0; i < (1 << DEF_SINE_ADDR_BITS); i++) begin
			a   = (HALF_PI_Q30 * u64_t'(2 * i + 1)) >> (DEF_SINE_ADDR_BITS + 1);
			a2  = (a * a) >> 30;
			t   = a;
			sum = longint'(a);
			for (int n = 1; n <= 5; n++) begin
				t = ((t * a2) >> 30) / u64_t'((2 * n) * (2 * n + 1));
				if (n % 2 == 1)
					sum = sum - longint'(t);
				else
					sum = sum + longint'(t);
			end
			if (sum < 0)
				sum = 0;
			v = (u64_t'(sum) * 32767 + (u64_t'(1) << 29)) >> 30;
			if (v > 32767)
				v = 32767;
			quarter_sine[i] = v[ROM_BITS-1:0];
		end
	end

	function automatic logic signed [15:0] predict_sample(input logic [31:0] ph);
		longint w;
		longint v;
		logic [31:0] y;
		logic [31:0] d;
		logic [DEF_SINE_ADDR_BITS-1:0] idx;
		case (shape_q)
			SHAPE_SQUARE: begin
				w = (ph != 0 && !ph[31]) ? 32768 : -32768;
			end
			SHAPE_TRIANGLE: begin
				// shift a quarter cycle so the peak lines up with the sine
				y = ph - 32'h4000_0000;
				d = y[31] ? (~y + 32'd1) : y;
				w = 32768 - longint'(d >> 15);
			end
			SHAPE_SAWTOOTH: begin
				w = longint'($signed(ph[31:16]));
			end
			default: begin
				idx = ph[29:20];
				if (ph[30])
					idx = ~idx;
				w = ph[31] ? -longint'(quarter_sine[idx]) : longint'(quarter_sine[idx]);
			end
		endcase
		v = ((longint'(amp_q) * w + 16384) >>> 15) + longint'(off_q);
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[15:0];
	endfunction

	// output side: ready with random stall bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			out_ready <= 1'b0;
			stall_left = stall_left - 1;
		end else if (idle_mode != 0 && $urandom_range(0, (idle_mode == 2) ? 2 : 9) == 0) begin
			out_ready <= 1'b0;
			stall_left = $urandom_range(0, 9);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// track register writes, predict on input items, check output items
	always @(posedge clk) begin : scoreboard
		logic signed [15:0] want;
		cycle_count = cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d samples pending", cycle_count,
				expected_samples.size());
			$display("status: fail");
			$finish;
		end else if (arst_n) begin
			if (cfg_write) begin
				case (reg_index_t'(cfg_index))
					REG_WAVE_SHAPE:   shape_q = shape_t'(cfg_data[1:0]);
					REG_PHASE_STEP:   step_q = cfg_data[STEP_BITS-1:0];
					REG_AMPLITUDE:    amp_q = cfg_data[AMP_BITS-1:0];
					REG_LEVEL_OFFSET: off_q = cfg_data[OFFSET_BITS-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (advance)
					phase_q = phase_q + step_q;
				expected_samples.push_back(row_known ? row_want : predict_sample(phase_q));
				item_count = item_count + 1;
			end
			if (out_valid && out_ready) begin
				sample_count = sample_count + 1;
				if (expected_samples.size() == 0) begin
					$error("sample: nothing expected, actual %0d", sample);
					mismatch_count = mismatch_count + 1;
				end else begin
					want = expected_samples.pop_front();
					if (sample !== want) begin
						$error("sample: expected %0d, actual %0d", want, sample);
						mismatch_count = mismatch_count + 1;
					end
				end
			end
		end
	end

	task automatic send_item(input logic adv, input logic known, input logic signed [15:0] want);
		in_valid <= 1'b1;
		advance <= adv;
		row_known <= known;
		row_want <= want;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic item_gap();
		if (idle_mode != 0 && $urandom_range(0, (idle_mode == 2) ? 1 : 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10))
				@(posedge clk);
		end
	endtask

	// hold off input until every pending sample is out
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_samples.size() != 0)
			@(posedge clk);
	endtask

	task automatic apply_settings(input logic [31:0] shape, input logic [31:0] step,
			input logic [31:0] amp, input logic [31:0] off);
		cfg_write <= 1'b1;
		cfg_index <= REG_WAVE_SHAPE;
		cfg_data <= shape;
		@(posedge clk);
		cfg_index <= REG_PHASE_STEP;
		cfg_data <= step;
		@(posedge clk);
		cfg_index <= REG_AMPLITUDE;
		cfg_data <= amp;
		@(posedge clk);
		cfg_index <= REG_LEVEL_OFFSET;
		cfg_data <= off;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
		settings_count = settings_count + 1;
	endtask

	initial begin : stimulus
		stim_row_t row;
		logic [31:0] cur_shape;
		logic [31:0] cur_step;
		logic [31:0] cur_amp;
		logic [31:0] cur_off;
		logic [31:0] r_shape;
		logic [31:0] r_step;
		logic [31:0] r_amp;
		logic [31:0] r_off;

		// shape, step, amplitude, offset, advance, known, sample
		directed_rows = '{
			'{32'(SHAPE_SINE), 32'h0, 32'h0, 32'h0, 1'b0, 1'b1, 16'sh0000},
			'{32'(SHAPE_SINE), 32'h0, 32'h0, 32'h0, 1'b1, 1'b1, 16'sh0000},
			'{32'(SHAPE_SQUARE), 32'h0, 32'h7FFF, 32'h0, 1'b0, 1'b1, 16'sh8001},
			'{32'(SHAPE_SQUARE), 32'h4000_0000, 32'h7FFF, 32'h0, 1'b1, 1'b1, 16'sh7FFF},
			'{32'(SHAPE_SQUARE), 32'h4000_0000, 32'h7FFF, 32'h0, 1'b1, 1'b1, 16'sh8001},
			'{32'(SHAPE_SQUARE), 32'h4000_0000, 32'h7FFF, 32'h0, 1'b0, 1'b1, 16'sh8001},
			'{32'(SHAPE_SQUARE), 32'h4000_0000, 32'h7FFF, 32'h7FFF, 1'b1, 1'b1, 16'sh0000},
			'{32'(SHAPE_SQUARE), 32'h4000_0000, 32'h7FFF, 32'h7FFF, 1'b1, 1'b1, 16'sh0000},
			'{32'(SHAPE_SQUARE), 32'h4000_0000, 32'h7FFF, 32'h7FFF, 1'b1, 1'b1, 16'sh7FFF},
			'{32'(SHAPE_SQUARE), 32'h4000_0000, 32'h7FFF, 32'h8000, 1'b0, 1'b1, 16'shFFFF},
			'{32'(SHAPE_SQUARE), 32'h4000_0000, 32'h7FFF, 32'h8000, 1'b1, 1'b1, 16'sh8000},
			'{32'(SHAPE_SAWTOOTH), 32'h4000_0000, 32'h7FFF, 32'h0, 1'b0, 1'b1, 16'sh8001},
			'{32'(SHAPE_SAWTOOTH), 32'h4000_0000, 32'h7FFF, 32'h0, 1'b1, 1'b0, 16'sh0000},
			'{32'(SHAPE_SAWTOOTH), 32'h4000_0000, 32'h7FFF, 32'h0, 1'b1, 1'b1, 16'sh0000},
			'{32'(SHAPE_TRIANGLE), 32'h4000_0000, 32'h7FFF, 32'h0, 1'b0, 1'b1, 16'sh0000},
			'{32'(SHAPE_TRIANGLE), 32'h4000_0000, 32'h7FFF, 32'h0, 1'b1, 1'b1, 16'sh7FFF},
			'{32'(SHAPE_TRIANGLE), 32'h4000_0000, 32'h7FFF, 32'h0, 1'b1, 1'b1, 16'sh0000},
			'{32'(SHAPE_TRIANGLE), 32'hFFFF_FFFF, 32'h7FFF, 32'h0, 1'b1, 1'b0, 16'sh0000},
			'{32'(SHAPE_SINE), 32'h1234_5678, 32'h7FFF, 32'h0, 1'b1, 1'b0, 16'sh0000},
			'{32'(SHAPE_SINE), 32'h1234_5678, 32'h7FFF, 32'h0, 1'b1, 1'b0, 16'sh0000},
			'{32'(SHAPE_SINE), 32'h1234_5678, 32'h7FFF, 32'h0, 1'b0, 1'b0, 16'sh0000},
			'{32'(SHAPE_SINE), 32'h1234_5678, 32'hFFFF_8000, 32'h0001_FFFF, 1'b1, 1'b1,
				16'shFFFF},
			'{{30'h3FFF_FFFF, SHAPE_SQUARE}, 32'h8000_0000, 32'h0001_7FFF, 32'h0, 1'b1,
				1'b0, 16'sh0000},
			'{{30'h3FFF_FFFF, SHAPE_TRIANGLE}, 32'h0, 32'h7FFF, 32'hFFFF_8000, 1'b1, 1'b0,
				16'sh0000},
			'{32'(SHAPE_SAWTOOTH), 32'h0001_0000, 32'h7FFF, 32'h0, 1'b1, 1'b0, 16'sh0000}
		};

		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		cur_shape = 32'(SHAPE_SINE);
		cur_step = '0;
		cur_amp = '0;
		cur_off = '0;
		idle_mode = 1;
		for (int r = 0; r < DIRECTED_COUNT; r++) begin
			row = directed_rows[r];
			if (row.shape != cur_shape || row.step != cur_step || row.amp != cur_amp ||
					row.off != cur_off) begin
				drain();
				apply_settings(row.shape, row.step, row.amp, row.off);
				cur_shape = row.shape;
				cur_step = row.step;
				cur_amp = row.amp;
				cur_off = row.off;
			end
			item_gap();
			send_item(row.adv, row.known, row.want);
		end

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			drain();
			// no idling at all in phase 4 and in the last two phases
			if (p >= RANDOM_PHASES - 2 || p == 4)
				idle_mode = 0;
			else
				idle_mode = (p % 2 == 0) ? 1 : 2;
			r_shape = {30'($urandom()), 2'(p)};
			case ($urandom_range(0, 4))
				0: r_step = 32'h0;
				1: r_step = 32'hFFFF_FFFF;
				2: r_step = $urandom_range(1, 65535);
				default: r_step = $urandom();
			endcase
			case ($urandom_range(0, 3))
				0: r_amp = {17'($urandom()), 15'h7FFF};
				1: r_amp = {17'($urandom()), 15'h0000};
				default: r_amp = $urandom();
			endcase
			case ($urandom_range(0, 4))
				0: r_off = {16'($urandom()), 16'h7FFF};
				1: r_off = {16'($urandom()), 16'h8000};
				2: r_off = 32'h0;
				default: r_off = $urandom();
			endcase
			apply_settings(r_shape, r_step, r_amp, r_off);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (p == 3 && k == PHASE_ITEMS / 2)
					drain();
				item_gap();
				send_item($urandom_range(0, 3) != 0, 1'b0, 16'sh0000);
			end
		end

		drain();
		repeat (8)
			@(posedge clk);
		$display("covered %0d items and %0d samples across %0d register settings,",
			item_count, sample_count, settings_count);
		$display("all four shapes, offset and amplitude extremes, wrap and saturation");
		if (mismatch_count == 0 && expected_samples.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/mwg_pkg.sv
rtl/core/multi_waveform_generator.sv
tb/sv/multi_waveform_generator_test.sv
